@@ rtl/egbw_pkg.sv @@
// Package for the Exp-Golomb bit stream writer.
// Holds operation codes, the command format between front and back, and sizes.
// No dependencies.
`default_nettype none

package egbw_pkg;

    localparam int ACC_W   = 32;
    localparam int CAP_W   = 25;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 25'h100_0000;

    localparam logic [2:0] OP_WRITE_BITS = 3'd0;
    localparam logic [2:0] OP_WRITE_BIT  = 3'd1;
    localparam logic [2:0] OP_UE         = 3'd2;
    localparam logic [2:0] OP_SE         = 3'd3;
    localparam logic [2:0] OP_FLUSH      = 3'd4;
    localparam logic [2:0] OP_RESTART    = 3'd5;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_FLUSH,
        CMD_RESTART,
        CMD_ERROR
    } cmd_kind_t;

    // A classified item: the bits to append (right-aligned) and their count.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [ACC_W-1:0]  bits;
        logic [5:0]        len;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/egbw_front.sv @@
// Front end of the bit stream writer: takes input items and turns them into
// commands with right-aligned code bits and a length. Depends on egbw_pkg.
`default_nettype none

module egbw_front
    import egbw_pkg::*;
(
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_operation,
    input  wire logic [31:0] s_value,
    input  wire logic [5:0]  s_bit_length,
    output logic             cmd_valid,
    input  wire logic        cmd_ready,
    output cmd_t             cmd
);

    logic [15:0] se_half;
    logic [15:0] se_mapped;
    logic [16:0] se_neg;
    logic [15:0] ue_src;
    logic [15:0] ue_code;
    logic [3:0]  ue_msb;
    logic [31:0] raw_mask;

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;

    // Signed values map to 2h-1 for positive h and to -2h for negative h.
    assign se_half = s_value[15:0];
    assign se_neg  = 17'h1_0000 - {1'b0, se_half};
    always_comb begin
        if (se_half == 16'h0000) begin
            se_mapped = 16'h0000;
        end else if (!se_half[15]) begin
            se_mapped = 16'({se_half, 1'b0} - 17'd1);
        end else begin
            se_mapped = {se_neg[14:0], 1'b0};
        end
    end

    assign ue_src  = (s_operation == OP_SE) ? se_mapped : s_value[15:0];
    assign ue_code = ue_src + 16'd1;

    always_comb begin
        ue_msb = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (ue_code[i]) begin
                ue_msb = 4'(i);
            end
        end
    end

    assign raw_mask = 32'hFFFF_FFFF >> (6'd32 - s_bit_length);

    always_comb begin
        cmd.kind = CMD_ERROR;
        cmd.bits = '0;
        cmd.len  = 6'd1;
        case (s_operation)
            OP_WRITE_BITS: begin
                if (s_bit_length != 6'd0 && s_bit_length <= 6'd32) begin
                    cmd.kind = CMD_WRITE;
                    cmd.bits = s_value & raw_mask;
                    cmd.len  = s_bit_length;
                end
            end
            OP_WRITE_BIT: begin
                cmd.kind = CMD_WRITE;
                cmd.bits = {31'd0, s_value[0]};
            end
            OP_UE: begin
                if (s_value <= 32'd65534) begin
                    cmd.kind = CMD_WRITE;
                    cmd.bits = {16'd0, ue_code};
                    cmd.len  = {1'b0, ue_msb, 1'b1};
                end
            end
            OP_SE: begin
                if (se_half != 16'h8000) begin
                    cmd.kind = CMD_WRITE;
                    cmd.bits = {16'd0, ue_code};
                    cmd.len  = {1'b0, ue_msb, 1'b1};
                end
            end
            OP_FLUSH: begin
                cmd.kind = CMD_FLUSH;
            end
            OP_RESTART: begin
                cmd.kind = CMD_RESTART;
            end
            default: begin
                cmd.kind = CMD_ERROR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/egbw_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on egbw_pkg for the command type.
`default_nettype none

module egbw_queue
    import egbw_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cmd_t in_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      out_cmd
);

    cmd_t       entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'(QUEUE_DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/egbw_back.sv @@
// Back end of the bit stream writer: holds the accumulator and byte count,
// carries out commands, streams one result per cycle unless m_ready stalls; uses egbw_pkg.
`default_nettype none

module egbw_back
    import egbw_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire cmd_t             cmd,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_byte_valid,
    output logic                  m_last,
    output logic                  m_error
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [5:0]       free_reg, free_next;
    logic [CAP_W-1:0] written_reg, written_next;
    logic [CAP_W-1:0] cap_reg;

    // Results still to be sent for the command taken last.
    logic [2:0]       pend_n_reg, pend_n_next;
    logic             pend_bytes_reg, pend_bytes_next;
    logic             pend_err_reg, pend_err_next;
    logic [ACC_W-1:0] pend_word_reg, pend_word_next;

    logic             m_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             byte_valid_reg, last_reg, error_reg;

    logic             slot_free, load, take;
    logic [5:0]       used;
    logic [6:0]       total;
    logic [6:0]       flush_sum;
    logic [2:0]       flush_n;
    logic [63:0]      window;
    logic             room4, room_flush;

    logic [2:0]       ex_n;
    logic             ex_bytes, ex_err;
    logic [ACC_W-1:0] ex_word;

    assign cfg_ready = 1'b1;

    assign slot_free = ~m_valid_reg | m_ready;
    assign load      = (pend_n_reg != 3'd0) & slot_free;
    assign cmd_ready = (pend_n_reg == 3'd0) | ((pend_n_reg == 3'd1) & load);
    assign take      = cmd_valid & cmd_ready;

    assign used      = 6'(ACC_W) - free_reg;
    assign total     = {1'b0, used} + {1'b0, cmd.len};
    assign window    = {acc_reg, 32'd0} | ({32'd0, cmd.bits} << 6'(7'd64 - total));
    assign flush_sum = {1'b0, used} + 7'd7;
    assign flush_n   = flush_sum[5:3];
    assign room4     = ({1'b0, written_reg} + 26'd4) <= {1'b0, cap_reg};
    assign room_flush = ({1'b0, written_reg} + 26'(flush_n)) <= {1'b0, cap_reg};

    always_comb begin
        acc_next     = acc_reg;
        free_next    = free_reg;
        written_next = written_reg;
        ex_n         = 3'd1;
        ex_bytes     = 1'b0;
        ex_err       = 1'b0;
        ex_word      = '0;
        case (cmd.kind)
            CMD_WRITE: begin
                if (total < 7'(ACC_W)) begin
                    acc_next  = window[63:32];
                    free_next = 6'(7'(ACC_W) - total);
                end else if (!room4) begin
                    ex_err = 1'b1;
                end else begin
                    ex_n         = 3'd4;
                    ex_bytes     = 1'b1;
                    ex_word      = window[63:32];
                    acc_next     = window[31:0];
                    free_next    = 6'(7'd64 - total);
                    written_next = written_reg + CAP_W'(4);
                end
            end
            CMD_FLUSH: begin
                if (flush_n == 3'd0) begin
                    ex_err = 1'b0;
                end else if (!room_flush) begin
                    ex_err = 1'b1;
                end else begin
                    ex_n         = flush_n;
                    ex_bytes     = 1'b1;
                    ex_word      = acc_reg;
                    acc_next     = '0;
                    free_next    = 6'(ACC_W);
                    written_next = written_reg + CAP_W'(flush_n);
                end
            end
            CMD_RESTART: begin
                acc_next     = '0;
                free_next    = 6'(ACC_W);
                written_next = '0;
            end
            default: begin
                ex_err = 1'b1;
            end
        endcase
    end

    always_comb begin
        pend_n_next     = pend_n_reg;
        pend_bytes_next = pend_bytes_reg;
        pend_err_next   = pend_err_reg;
        pend_word_next  = pend_word_reg;
        if (take) begin
            pend_n_next     = ex_n;
            pend_bytes_next = ex_bytes;
            pend_err_next   = ex_err;
            pend_word_next  = ex_word;
        end else if (load) begin
            pend_n_next    = pend_n_reg - 3'd1;
            pend_word_next = {pend_word_reg[ACC_W-9:0], 8'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            free_reg    <= 6'(ACC_W);
            written_reg <= '0;
            cap_reg     <= CAP_RESET;
            pend_n_reg  <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                acc_reg     <= acc_next;
                free_reg    <= free_next;
                written_reg <= written_next;
            end
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            pend_n_reg <= pend_n_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_bytes_reg <= pend_bytes_next;
        pend_err_reg   <= pend_err_next;
        pend_word_reg  <= pend_word_next;
        if (load) begin
            out_byte_reg   <= pend_bytes_reg ? pend_word_reg[ACC_W-1:ACC_W-8] : 8'd0;
            byte_valid_reg <= pend_bytes_reg;
            last_reg       <= (pend_n_reg == 3'd1);
            error_reg      <= ~pend_bytes_reg & pend_err_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_byte_valid = byte_valid_reg;
    assign m_last       = last_reg;
    assign m_error      = error_reg;

endmodule

`default_nettype wire

@@ rtl/exp_golomb_bitstream_writer_top.sv @@
// Top level of the Exp-Golomb bit stream writer.
// Instantiates egbw_front, egbw_queue and egbw_back; depends on egbw_pkg.
//
// Packs raw bits, single bits and unsigned or signed Exp-Golomb codes MSB
// first into a 32-bit accumulator and sends out one result per cycle on the
// m_ channel unless m_ready stalls it: a stream byte, or one status result
// (with the error flag) for an item that emits no byte. An item has one to
// four results: one for a status-only item and four for an item that fills
// the accumulator or flushes four bytes. Items are written into a two-entry
// command queue at the edge that accepts them, the back end takes a command
// at the next edge at the earliest, and each result of a taken command is
// held in the pending registers and then registered into the output register.
// The user must write buffer_size on the cfg_ channel only while the block
// is idle; the block itself does not enforce this. It resets to 16777216.

`default_nettype none

module exp_golomb_bitstream_writer_top
    import egbw_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [2:0]       s_operation,
    input  wire logic [31:0]      s_value,
    input  wire logic [5:0]       s_bit_length,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_byte_valid,
    output logic                  m_last,
    output logic                  m_error
);

    logic front_valid, front_ready;
    cmd_t front_cmd;
    logic back_valid, back_ready;
    cmd_t back_cmd;

    egbw_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_value      (s_value),
        .s_bit_length (s_bit_length),
        .cmd_valid    (front_valid),
        .cmd_ready    (front_ready),
        .cmd          (front_cmd)
    );

    egbw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    egbw_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .cmd_valid    (back_valid),
        .cmd_ready    (back_ready),
        .cmd          (back_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_last       (m_last),
        .m_error      (m_error)
    );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for exp_golomb_bitstream_writer_top: directed and random items checked
// against a bit-exact encoder model kept here. Depends on egbw_pkg and the RTL only.

module tb;
    import egbw_pkg::*;

    // Operation codes that the block must reject.
    localparam logic [2:0] OP_RESERVED_6 = 3'd6;
    localparam logic [2:0] OP_RESERVED_7 = 3'd7;

    localparam logic [CAP_W-1:0] CAP_MAX = '1;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned HOLD_OFF_CYCLES = 160;
    localparam int unsigned PHASE_ITEMS = 51;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       error;
    } stream_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [2:0]       s_operation = OP_RESTART;
    logic [31:0]      s_value = '0;
    logic [5:0]       s_bit_length = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [7:0]       m_out_byte;
    logic             m_byte_valid;
    logic             m_last;
    logic             m_error;

    exp_golomb_bitstream_writer_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_value      (s_value),
        .s_bit_length (s_bit_length),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_last       (m_last),
        .m_error      (m_error)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Encoder state as the block should hold it.
    logic [31:0]      acc_word = '0;
    int unsigned      free_bits_left = 32;
    int unsigned      bytes_out = 0;
    logic [CAP_W-1:0] capacity = CAP_RESET;

    stream_result_t pending_out[$];
    int unsigned    mismatches = 0;
    int unsigned    quiet_cycles = 0;
    bit             no_idle = 1'b0;
    bit             hold_off_req = 1'b0;

    function automatic void push_result(logic [7:0] b, logic bv, logic lst, logic err);
        stream_result_t r;
        r.out_byte   = b;
        r.byte_valid = bv;
        r.last       = lst;
        r.error      = err;
        pending_out.push_back(r);
    endfunction

    function automatic bit has_room(int unsigned n);
        return longint'(bytes_out) + longint'(n) <= longint'(capacity);
    endfunction

    // Top n bytes of the word go out, most significant first.
    function automatic void emit_word(logic [31:0] w, int unsigned n);
        for (int i = 0; i < n; i++) begin
            push_result(w[31-8*i -: 8], 1'b1, i + 1 == n, 1'b0);
        end
        bytes_out += n;
    endfunction

    function automatic void append_bits(logic [31:0] v, int unsigned n);
        int unsigned total;
        logic [63:0] field;
        logic [63:0] window;
        total = 32 - free_bits_left + n;
        field = {32'b0, v} & ((64'd1 << n) - 64'd1);
        window = {acc_word, 32'b0} | (field << (64 - total));
        if (total < 32) begin
            acc_word = window[63:32];
            free_bits_left = 32 - total;
            push_result(8'h00, 1'b0, 1'b1, 1'b0);
        end else if (!has_room(4)) begin
            push_result(8'h00, 1'b0, 1'b1, 1'b1);
        end else begin
            emit_word(window[63:32], 4);
            acc_word = window[31:0];
            free_bits_left = 64 - total;
        end
    endfunction

    function automatic void append_ue(logic [31:0] v);
        logic [31:0] code;
        logic [31:0] x;
        int unsigned nbits;
        if (v > 32'd65534) begin
            push_result(8'h00, 1'b0, 1'b1, 1'b1);
            return;
        end
        code = v + 32'd1;
        nbits = 0;
        for (x = code >> 1; x != 0; x = x >> 1) nbits++;
        append_bits(code, 2 * nbits + 1);
    endfunction

    function automatic void encode_item(logic [2:0] op, logic [31:0] val, logic [5:0] len);
        logic [15:0] half;
        int unsigned n;
        case (op)
            OP_WRITE_BITS: begin
                if (len == 0 || len > 32) push_result(8'h00, 1'b0, 1'b1, 1'b1);
                else append_bits(val, len);
            end
            OP_WRITE_BIT: append_bits({31'b0, val[0]}, 1);
            OP_UE: append_ue(val);
            OP_SE: begin
                half = val[15:0];
                // The most negative 16-bit value has no code.
                if (half == 16'h8000) push_result(8'h00, 1'b0, 1'b1, 1'b1);
                else if (half == 16'h0000) append_ue(32'd0);
                else if (half < 16'h8000) append_ue(32'd2 * half - 32'd1);
                else append_ue(32'd2 * (32'h10000 - half));
            end
            OP_FLUSH: begin
                n = (32 - free_bits_left + 7) / 8;
                if (n == 0) begin
                    push_result(8'h00, 1'b0, 1'b1, 1'b0);
                end else if (!has_room(n)) begin
                    push_result(8'h00, 1'b0, 1'b1, 1'b1);
                end else begin
                    emit_word(acc_word, n);
                    acc_word = '0;
                    free_bits_left = 32;
                end
            end
            OP_RESTART: begin
                acc_word = '0;
                free_bits_left = 32;
                bytes_out = 0;
                push_result(8'h00, 1'b0, 1'b1, 1'b0);
            end
            default: push_result(8'h00, 1'b0, 1'b1, 1'b1);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Result checker: every transfer on the m_ side is matched with the oldest expectation.
    always @(posedge aclk) begin : check_out
        stream_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_out.size() == 0) begin
                report_mismatch("result with nothing expected", 32'(m_out_byte), 32'd0);
            end else begin
                want = pending_out.pop_front();
                if (m_out_byte !== want.out_byte)
                    report_mismatch("out_byte", 32'(m_out_byte), 32'(want.out_byte));
                if (m_byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", 32'(m_byte_valid), 32'(want.byte_valid));
                if (m_last !== want.last)
                    report_mismatch("last", 32'(m_last), 32'(want.last));
                if (m_error !== want.error)
                    report_mismatch("error", 32'(m_error), 32'(want.error));
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 24);
            end
        end
    end

    task automatic send_item(input logic [2:0] op, input logic [31:0] val, input logic [5:0] len);
        if (!no_idle) begin
            while ($urandom_range(99) < 24) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_value      <= val;
        s_bit_length <= len;
        do @(posedge aclk); while (!s_ready);
        encode_item(op, val, len);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        capacity = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_item();
        int unsigned pick;
        int unsigned sub;
        logic [31:0] val;
        logic [15:0] mag;
        pick = $urandom_range(99);
        val  = $urandom();
        if (pick < 30) begin
            send_item(OP_WRITE_BITS, val, 6'($urandom_range(1, 32)));
        end else if (pick < 45) begin
            send_item(OP_WRITE_BIT, val, 6'($urandom_range(0, 63)));
        end else if (pick < 60) begin
            send_item(OP_UE, $urandom_range(0, (32'd1 << $urandom_range(0, 16)) - 1),
                      6'($urandom_range(0, 63)));
        end else if (pick < 75) begin
            mag = 16'($urandom_range(0, (32'd1 << $urandom_range(0, 15)) - 1));
            if ($urandom_range(1)) mag = 16'h0000 - mag;
            send_item(OP_SE, {val[31:16], mag}, 6'($urandom_range(0, 63)));
        end else if (pick < 85) begin
            send_item(OP_FLUSH, val, 6'($urandom_range(0, 63)));
        end else if (pick < 90) begin
            send_item(OP_RESTART, val, 6'($urandom_range(0, 63)));
        end else begin
            // Malformed items: bad length, reserved codes, out-of-range codes.
            sub = $urandom_range(3);
            case (sub)
                0: send_item(OP_WRITE_BITS, val,
                             $urandom_range(1) ? 6'd0 : 6'($urandom_range(33, 63)));
                1: send_item($urandom_range(1) ? OP_RESERVED_6 : OP_RESERVED_7, val,
                             6'($urandom_range(0, 63)));
                2: send_item(OP_UE, val | 32'h0001_0000, 6'($urandom_range(0, 63)));
                default: send_item(OP_SE, {val[31:16], 16'h8000}, 6'($urandom_range(0, 63)));
            endcase
        end
    endtask

    task automatic test_basic_codes();
        send_item(OP_WRITE_BITS, 32'h0000_0001, 6'd1);
        send_item(OP_WRITE_BITS, 32'hFFFF_FFFF, 6'd32);
        send_item(OP_WRITE_BITS, 32'h1234_5678, 6'd0);
        send_item(OP_WRITE_BITS, 32'h1234_5678, 6'd33);
        send_item(OP_WRITE_BITS, 32'h1234_5678, 6'd63);
        send_item(OP_WRITE_BITS, 32'hFFFF_FFF5, 6'd4);
        send_item(OP_WRITE_BIT, 32'hFFFF_FFFE, 6'd0);
        send_item(OP_WRITE_BIT, 32'h0000_0001, 6'd63);
        send_item(OP_UE, 32'd0, 6'd0);
        send_item(OP_UE, 32'd65534, 6'd0);
        send_item(OP_UE, 32'd65535, 6'd0);
        send_item(OP_UE, 32'hFFFF_FFFF, 6'd0);
        send_item(OP_SE, 32'h0000_0000, 6'd0);
        send_item(OP_SE, 32'h0000_0001, 6'd0);
        send_item(OP_SE, 32'h0000_FFFF, 6'd0);
        send_item(OP_SE, 32'h0000_7FFF, 6'd0);
        send_item(OP_SE, 32'h0000_8001, 6'd0);
        send_item(OP_SE, 32'h0000_8000, 6'd0);
        send_item(OP_SE, 32'hABCD_0002, 6'd0);
        send_item(OP_FLUSH, 32'd0, 6'd0);
        send_item(OP_FLUSH, 32'd0, 6'd0);
        send_item(OP_WRITE_BITS, 32'h0000_0015, 6'd5);
        send_item(OP_RESTART, 32'd0, 6'd0);
        send_item(OP_RESERVED_6, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_RESERVED_7, 32'd0, 6'd1);
    endtask

    task automatic test_buffer_full();
        wait_drained();
        write_capacity(25'd1);
        send_item(OP_RESTART, 32'd0, 6'd0);
        send_item(OP_WRITE_BITS, 32'h0000_00A5, 6'd8);
        send_item(OP_FLUSH, 32'd0, 6'd0);
        send_item(OP_WRITE_BIT, 32'd1, 6'd0);
        send_item(OP_FLUSH, 32'd0, 6'd0);
        send_item(OP_WRITE_BITS, 32'h7FFF_FFFF, 6'd31);
        send_item(OP_RESTART, 32'd0, 6'd0);
        wait_drained();
        write_capacity(25'd4);
        send_item(OP_WRITE_BITS, 32'hDEAD_BEEF, 6'd32);
        send_item(OP_WRITE_BITS, 32'hCAFE_F00D, 6'd32);
        send_item(OP_FLUSH, 32'd0, 6'd0);
    endtask

    task automatic test_capacity_lowered();
        wait_drained();
        write_capacity(CAP_MAX);
        send_item(OP_RESTART, 32'd0, 6'd0);
        repeat (3) send_item(OP_WRITE_BITS, $urandom(), 6'd32);
        wait_drained();
        // Capacity below the bytes already written: emitting must fail until a restart.
        write_capacity(25'd5);
        send_item(OP_WRITE_BITS, $urandom(), 6'd32);
        send_item(OP_WRITE_BITS, $urandom(), 6'd4);
        send_item(OP_FLUSH, 32'd0, 6'd0);
        send_item(OP_RESTART, 32'd0, 6'd0);
        send_item(OP_WRITE_BITS, $urandom(), 6'd32);
        send_item(OP_FLUSH, 32'd0, 6'd0);
    endtask

    task automatic test_random_stream();
        logic [CAP_W-1:0] caps[4];
        caps[0] = CAP_MAX;
        caps[1] = 25'($urandom_range(2, 40));
        caps[2] = 25'd1;
        caps[3] = CAP_RESET;
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            write_capacity(caps[p]);
            no_idle = (p == 1);
            repeat (PHASE_ITEMS) send_random_item();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        wait_drained();
        write_capacity(CAP_MAX);
        hold_off_req = 1'b1;
        no_idle = 1'b1;
        repeat (20) send_item(OP_WRITE_BITS, $urandom(), 6'd32);
        no_idle = 1'b0;
        send_item(OP_FLUSH, 32'd0, 6'd0);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_basic_codes();
        test_buffer_full();
        test_capacity_lowered();
        test_random_stream();
        test_output_stall();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (pending_out.size() != 0)
            report_mismatch("results never delivered", 32'd0, 32'(pending_out.size()));
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
